// ===== design/dape_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dape_pkg
// Shared types, constants and helpers for the dual-antenna position estimator.
// ----------------------------------------------------------------------------
package dape_pkg;

    localparam int QW = 8;      // link quality width
    localparam int PW = 7;      // percent width

    // Position fixed point, 16 fraction bits
    localparam logic [16:0] Q16_HALF = 17'd32768;
    // Offset magnitude at which the clamp to -0.05 / 1.05 takes over
    localparam logic [15:0] T_SAT    = 16'd36045;
    localparam logic [PW-1:0] PCT_RESET = 7'd50;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    // Completed antenna pair handed from front to back
    typedef struct packed {
        logic          player;
        logic [QW-1:0] q_upper;
        logic [QW-1:0] q_lower;
    } dape_job_t;

    // Round 0..127 to the nearest ten, capped at 100
    function automatic logic [PW-1:0] round_ten(input logic [PW-1:0] v);
        logic [15:0] m;
        logic [4:0]  q;
        logic [8:0]  r;
        m = (16'(v) + 16'd5) * 16'd205;   // /10 via reciprocal, exact here
        q = m[15:11];
        r = 9'(q) * 9'd10;
        if (r > 9'd100) begin
            r = 9'd100;
        end
        return r[PW-1:0];
    endfunction

endpackage

// ===== design/dape_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dape_front
// Takes reports, keeps latest quality and pending flags, emits pair jobs.
// ----------------------------------------------------------------------------
module dape_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [15:0]         s_tdata,   // [1:0] antenna, [9:2] quality
    output logic                job_valid,
    input  logic                job_ready,
    output dape_pkg::dape_job_t job
);
    import dape_pkg::*;

    logic [QW-1:0] quality_reg [4];
    logic [3:0]    pending_reg;
    logic [1:0]    antenna;
    logic [1:0]    partner;
    logic [QW-1:0] q_in;
    logic [QW-1:0] q_partner;
    logic          accept;

    assign antenna   = s_tdata[1:0];
    assign q_in      = s_tdata[9:2];
    assign partner   = antenna ^ 2'b01;
    assign q_partner = quality_reg[partner];

    // Only a pair-completing item needs room in the queue; keep it simple
    // and stall on a full queue.
    assign s_tready  = job_ready;
    assign accept    = s_tvalid & s_tready;
    assign job_valid = s_tvalid & pending_reg[partner];

    always_comb begin
        job.player  = antenna[1];
        job.q_upper = antenna[0] ? q_partner : q_in;
        job.q_lower = antenna[0] ? q_in : q_partner;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                quality_reg[i] <= '0;
            end
        end else if (accept) begin
            quality_reg[antenna] <= q_in;
            if (pending_reg[partner]) begin
                pending_reg[partner] <= 1'b0;
                pending_reg[antenna] <= 1'b0;
            end else begin
                pending_reg[antenna] <= 1'b1;
            end
        end
    end

endmodule

// ===== design/dape_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dape_fifo
// Two-entry job queue between front and back.
// ----------------------------------------------------------------------------
module dape_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  dape_pkg::dape_job_t in_job,
    output logic                out_valid,
    input  logic                out_ready,
    output dape_pkg::dape_job_t out_job
);
    import dape_pkg::*;

    dape_job_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== design/dape_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dape_back
// Position sequencer: gain scaling, divide by reciprocal, smoothing, output.
// ----------------------------------------------------------------------------
module dape_back #(
    parameter int TABLE_HEIGHT = 80
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [15:0]         gain,
    input  logic                job_valid,
    output logic                job_ready,
    input  dape_pkg::dape_job_t job,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata    // [0] player, [7:1] position_pct
);
    import dape_pkg::*;

    // offset t = floor(666 * gain * |d| / (125 * H))
    localparam logic [31:0] DIVISOR   = 32'(125 * TABLE_HEIGHT);
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(DIVISOR);
    localparam logic [31:0] RECIP_M   = RECIP_FULL[31:0];
    localparam logic [33:0] SAT_LIMIT = 34'(36046) * 34'(DIVISOR);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL1  = 6'b000010,
        ST_MUL2  = 6'b000100,
        ST_RECIP = 6'b001000,
        ST_FIX   = 6'b010000,
        ST_POS   = 6'b100000
    } back_state_t;

    back_state_t   state_reg, state_next;
    logic          player_reg;
    logic          neg_reg;
    logic [QW-1:0] mag_reg;
    logic [23:0]   prod1_reg;
    logic [30:0]   num_reg;
    logic          sat_reg;
    logic [15:0]   q0_reg;
    logic [15:0]   t_reg;
    logic [PW-1:0] prev_reg [2];
    logic          out_valid_reg;
    logic [7:0]    out_data_reg;

    logic [33:0]        num_full;
    logic [62:0]        recip_prod;
    logic [31:0]        qd;
    logic [31:0]        rem;
    logic signed [17:0] pos_q16;
    logic signed [24:0] mix;
    logic [PW-1:0]      pct;
    logic [PW-1:0]      pct_round;
    logic               out_free;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = ~out_valid_reg | m_tready;

    always_comb begin
        num_full   = 34'(prod1_reg) * 34'd666;
        recip_prod = 63'(num_reg) * 63'(RECIP_M);
        qd         = 32'(q0_reg) * DIVISOR;
        rem        = 32'(num_reg) - qd;
        pos_q16    = neg_reg ? $signed(18'(Q16_HALF) + 18'(t_reg))
                             : $signed(18'(Q16_HALF) - 18'(t_reg));
        mix        = 25'(pos_q16) * 25'sd100
                   + $signed({2'b00, prev_reg[player_reg], 16'd0});
        pct        = mix[24] ? '0 : mix[23:17];
        pct_round  = round_ten(pct);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (job_valid) state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_RECIP;
            ST_RECIP: state_next = ST_FIX;
            ST_FIX:   state_next = ST_POS;
            ST_POS:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                player_reg <= job.player;
                neg_reg    <= (job.q_upper < job.q_lower);
                mag_reg    <= (job.q_upper >= job.q_lower) ? job.q_upper - job.q_lower
                                                           : job.q_lower - job.q_upper;
            end
            ST_MUL1:  prod1_reg <= 24'(mag_reg) * 24'(gain);
            ST_MUL2: begin
                sat_reg <= (num_full >= SAT_LIMIT);
                num_reg <= num_full[30:0];
            end
            ST_RECIP: q0_reg <= recip_prod[47:32];
            ST_FIX: begin
                if (sat_reg) begin
                    t_reg <= T_SAT;
                end else if (rem >= DIVISOR) begin
                    t_reg <= q0_reg + 16'd1;
                end else begin
                    t_reg <= q0_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_reg[0]   <= PCT_RESET;
            prev_reg[1]   <= PCT_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_POS && out_free) begin
                out_valid_reg        <= 1'b1;
                out_data_reg         <= {pct_round, player_reg};
                prev_reg[player_reg] <= pct_round;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== design/dual_antenna_position_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_antenna_position_estimator_core
// Two-player position estimate from paired upper/lower antenna link quality.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per link-quality report, tdata[1:0] = antenna,
//     tdata[9:2] = quality. Antennas 0/1 belong to player 0, 2/3 to player 1;
//     even is the upper antenna.
//   m_ channel: one item when a report completes a pending antenna pair,
//     tdata[0] = player, tdata[7:1] = smoothed position in percent (0..100,
//     a multiple of ten).
//   cfg_ channel: writes the Q4.12 gain; always ready. Write only while idle.
// Flow:
//   Every report waits while the queue is full. A completing report
//   queues a job (two-entry queue); the back sequencer steps through
//   load, two multiplies, reciprocal multiply, remainder fix and
//   smoothing/round per job, and takes a new job only in idle.
// Reset (aresetn low, synchronous): gain 1.0, qualities 0, no pending flags,
//   both previous positions 50 %, queue and output empty.
// Back-pressure: a held m_ item stalls the sequencer at its last step; the
//   queue then fills and s_tready drops until room frees up.
// ----------------------------------------------------------------------------
module dual_antenna_position_estimator_core #(
    parameter int TABLE_HEIGHT = 80
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] antenna, [9:2] quality
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [0] player, [7:1] position_pct
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // gain, Q4.12
);
    import dape_pkg::*;

    logic [15:0] gain_reg;

    dape_job_t   front_job;
    logic        front_valid;
    logic        front_ready;
    dape_job_t   back_job;
    logic        back_valid;
    logic        back_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            gain_reg <= cfg_data;
        end
    end

    // Front: report intake, pairing
    dape_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (front_valid),
        .job_ready (front_ready),
        .job       (front_job)
    );

    // Decoupling queue
    dape_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_job    (front_job),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_job   (back_job)
    );

    // Back: position arithmetic and output register
    dape_back #(
        .TABLE_HEIGHT (TABLE_HEIGHT)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (gain_reg),
        .job_valid (back_valid),
        .job_ready (back_ready),
        .job       (back_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Results are always a multiple of ten in 0..100
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:1] == 7'd0  || m_tdata[7:1] == 7'd10 ||
                      m_tdata[7:1] == 7'd20 || m_tdata[7:1] == 7'd30 ||
                      m_tdata[7:1] == 7'd40 || m_tdata[7:1] == 7'd50 ||
                      m_tdata[7:1] == 7'd60 || m_tdata[7:1] == 7'd70 ||
                      m_tdata[7:1] == 7'd80 || m_tdata[7:1] == 7'd90 ||
                      m_tdata[7:1] == 7'd100))
        else $error("position out of range or not a multiple of ten");

    // Once the back takes a job it is busy for the following cycles
    a_back_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (back_valid && back_ready) |=> !back_ready ##1 !back_ready)
        else $error("back sequencer took a job while busy");

    // A result appears only after a job has been through the back
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!back_ready))
        else $error("result without a job in progress");

endmodule
